[hdl/task_name_registry_table_macros.svh]
// ----------------------------------------------------------------------------
// Task name registry table - assertion macros
// Shared concurrent assertion forms on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef TASK_NAME_REGISTRY_TABLE_MACROS_SVH
`define TASK_NAME_REGISTRY_TABLE_MACROS_SVH

// check outside of reset
`define TNRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define TNRT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tnrt_pkg.sv]
// ----------------------------------------------------------------------------
// Task name registry table - package
// Widths, request and status codes, and control groups shared by the block.
// ----------------------------------------------------------------------------
package tnrt_pkg;

    localparam int OPCODE_W        = 2;
    localparam int NAME_W          = 64;
    localparam int ID_W            = 16;
    localparam int STATUS_W        = 3;
    localparam int TABLE_ENTRIES_D = 16;
    localparam int NAME_BYTES_D    = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_GET        = 2'd0,
        OP_REGISTER   = 2'd1,
        OP_UNREGISTER = 2'd2,
        OP_INVALID    = 2'd3
    } tnrt_opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_BAD_PARAM    = 3'd1,
        ST_NOT_REG      = 3'd2,
        ST_NAME_TAKEN   = 3'd3,
        ST_TABLE_FULL   = 3'd4,
        ST_UNAUTHORIZED = 3'd5
    } tnrt_status_t;

    typedef struct packed {
        logic rename;
        logic alloc;
        logic clear;
    } tnrt_wr_cmd_t;

    typedef struct packed {
        logic name_hit;
        logic owner_hit;
        logic free_hit;
    } tnrt_hit_t;

endpackage

[hdl/tnrt_req_if.sv]
// ----------------------------------------------------------------------------
// Task name registry table - request channel
// Valid/ready channel carrying one registry request item.
// ----------------------------------------------------------------------------
interface tnrt_req_if
    import tnrt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [NAME_W-1:0]   name_bytes;
    logic [ID_W-1:0]     caller_id;
    logic                caller_is_user;

    modport source (
        output valid, opcode, name_bytes, caller_id, caller_is_user,
        input  ready
    );

    modport sink (
        input  valid, opcode, name_bytes, caller_id, caller_is_user,
        output ready
    );
endinterface

[hdl/tnrt_rsp_if.sv]
// ----------------------------------------------------------------------------
// Task name registry table - response channel
// Valid/ready channel carrying one registry result item.
// ----------------------------------------------------------------------------
interface tnrt_rsp_if
    import tnrt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     found_id;

    modport source (
        output valid, status, found_id,
        input  ready
    );

    modport sink (
        input  valid, status, found_id,
        output ready
    );
endinterface

[hdl/tnrt_table.sv]
// ----------------------------------------------------------------------------
// Task name registry table - entry store
// Holds the entries, matches name, owner and free slots in parallel and
// applies one row update per cycle.
// ----------------------------------------------------------------------------
`include "task_name_registry_table_macros.svh"

module tnrt_table
    import tnrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_D,
    parameter int LABEL_W       = NAME_BYTES_D * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [LABEL_W-1:0]       name,
    input  logic [ID_W-1:0]          caller,
    input  logic [TABLE_ENTRIES-1:0] wr_sel,
    input  tnrt_wr_cmd_t             wr_cmd,
    output tnrt_hit_t                hits,
    output logic [ID_W-1:0]          name_owner,
    output logic [TABLE_ENTRIES-1:0] name_sel,
    output logic [TABLE_ENTRIES-1:0] owner_sel,
    output logic [TABLE_ENTRIES-1:0] free_sel
);

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [ID_W-1:0]          owner_reg [TABLE_ENTRIES];
    logic [ID_W-1:0]          owner_next [TABLE_ENTRIES];
    logic [LABEL_W-1:0]       label_reg [TABLE_ENTRIES];
    logic [LABEL_W-1:0]       label_next [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] name_match;
    logic [TABLE_ENTRIES-1:0] owner_match;
    logic [TABLE_ENTRIES-1:0] free_match;

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            name_match[i]  = valid_reg[i] && (label_reg[i] == name);
            owner_match[i] = valid_reg[i] && (owner_reg[i] == caller);
            free_match[i]  = !valid_reg[i];
        end
    end

    // isolate lowest set bit
    assign name_sel  = name_match  & (~name_match  + TABLE_ENTRIES'(1));
    assign owner_sel = owner_match & (~owner_match + TABLE_ENTRIES'(1));
    assign free_sel  = free_match  & (~free_match  + TABLE_ENTRIES'(1));

    assign hits.name_hit  = |name_match;
    assign hits.owner_hit = |owner_match;
    assign hits.free_hit  = |free_match;

    always_comb
    begin
        name_owner = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            name_owner = name_owner | (owner_reg[i] & {ID_W{name_sel[i]}});
        end
    end

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
            owner_next[i] = owner_reg[i];
            label_next[i] = label_reg[i];
            if (wr_sel[i])
            begin
                if (wr_cmd.clear)
                begin
                    valid_next[i] = 1'b0;
                end
                if (wr_cmd.alloc)
                begin
                    valid_next[i] = 1'b1;
                    owner_next[i] = caller;
                end
                if (wr_cmd.alloc || wr_cmd.rename)
                begin
                    label_next[i] = name;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            owner_reg[i] <= owner_next[i];
            label_reg[i] <= label_next[i];
        end
    end

    `TNRT_ASSERT(a_name_sel_onehot, $onehot0(name_sel), "name select not one-hot")
    `TNRT_ASSERT(a_alloc_sets_valid, (|(wr_sel & free_sel)) && wr_cmd.alloc |=> (valid_reg != $past(valid_reg)), "allocation did not take a free entry")
    `TNRT_ASSERT(a_clear_drops_valid, (|wr_sel) && wr_cmd.clear |=> ($countones(valid_reg) + 1 == $countones($past(valid_reg))), "unregister did not free exactly one entry")

endmodule

[hdl/task_name_registry_table.sv]
// ----------------------------------------------------------------------------
// Task name registry table - top level
// Maps names of up to NAME_BYTES bytes to 16-bit task IDs.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request item (get, register, unregister) with the name,
//   the caller's task ID and its user bit. rsp returns one item per request:
//   a status code and, for a successful get, the owner ID.
//   An item taken on req is registered in the input stage; its result is
//   then registered in the rsp stage and shown on rsp.
//   Throughput: one item per cycle while rsp is not stalled. The whole
//   table is searched combinationally by per-entry comparators and
//   lowest-index pick; the row update lands at the same edge that registers
//   the result, so the next item already sees it.
//   Reset empties the table at once (entry valid bits clear); no sweep.
//   When the receiver stalls, the result holds on rsp, one more item is
//   taken into the input stage, and req.ready then drops until rsp moves.
// ----------------------------------------------------------------------------
`include "task_name_registry_table_macros.svh"

module task_name_registry_table
    import tnrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_D,
    parameter int NAME_BYTES    = NAME_BYTES_D
) (
    input  logic       clk,
    input  logic       rst_n,
    tnrt_req_if.sink   req,
    tnrt_rsp_if.source rsp
);

    localparam int LABEL_W = NAME_BYTES * 8;

    logic                     s1_valid_reg;
    tnrt_opcode_t             s1_op_reg;
    logic [LABEL_W-1:0]       s1_name_reg;
    logic [LABEL_W-1:0]       s1_name_next;
    logic [ID_W-1:0]          s1_caller_reg;
    logic                     s1_user_reg;

    logic                     rsp_valid_reg;
    tnrt_status_t             rsp_status_reg;
    tnrt_status_t             rsp_status_next;
    logic [ID_W-1:0]          rsp_id_reg;
    logic [ID_W-1:0]          rsp_id_next;

    logic                     advance;
    logic                     s1_fire;
    logic                     name_empty;
    tnrt_hit_t                hits;
    logic [ID_W-1:0]          name_owner;
    logic [TABLE_ENTRIES-1:0] name_sel;
    logic [TABLE_ENTRIES-1:0] owner_sel;
    logic [TABLE_ENTRIES-1:0] free_sel;
    logic [TABLE_ENTRIES-1:0] wr_sel;
    tnrt_wr_cmd_t             wr_cmd;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;

    // cut the name at its first zero byte
    always_comb
    begin
        logic alive;
        alive        = 1'b1;
        s1_name_next = '0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (req.name_bytes[8*i +: 8] == 8'd0)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                s1_name_next[8*i +: 8] = req.name_bytes[8*i +: 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_op_reg     <= tnrt_opcode_t'(req.opcode);
            s1_name_reg   <= s1_name_next;
            s1_caller_reg <= req.caller_id;
            s1_user_reg   <= req.caller_is_user;
        end
    end

    tnrt_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .LABEL_W       (LABEL_W)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .name       (s1_name_reg),
        .caller     (s1_caller_reg),
        .wr_sel     (wr_sel),
        .wr_cmd     (wr_cmd),
        .hits       (hits),
        .name_owner (name_owner),
        .name_sel   (name_sel),
        .owner_sel  (owner_sel),
        .free_sel   (free_sel)
    );

    assign name_empty = (s1_name_reg[7:0] == 8'd0);

    always_comb
    begin
        tnrt_wr_cmd_t             cmd;
        logic [TABLE_ENTRIES-1:0] sel;
        rsp_status_next = ST_BAD_PARAM;
        rsp_id_next     = '0;
        cmd             = '0;
        sel             = '0;
        case (s1_op_reg)
            OP_GET:
            begin
                if (name_empty)
                begin
                    rsp_status_next = ST_BAD_PARAM;
                end
                else if (hits.name_hit)
                begin
                    rsp_status_next = ST_OK;
                    rsp_id_next     = name_owner;
                end
                else
                begin
                    rsp_status_next = ST_NOT_REG;
                end
            end
            OP_REGISTER:
            begin
                if (name_empty)
                begin
                    rsp_status_next = ST_BAD_PARAM;
                end
                else if (s1_user_reg)
                begin
                    rsp_status_next = ST_UNAUTHORIZED;
                end
                else if (hits.name_hit)
                begin
                    rsp_status_next = (name_owner == s1_caller_reg) ? ST_OK : ST_NAME_TAKEN;
                end
                else if (hits.owner_hit)
                begin
                    rsp_status_next = ST_OK;
                    cmd.rename      = 1'b1;
                    sel             = owner_sel;
                end
                else if (hits.free_hit)
                begin
                    rsp_status_next = ST_OK;
                    cmd.alloc       = 1'b1;
                    sel             = free_sel;
                end
                else
                begin
                    rsp_status_next = ST_TABLE_FULL;
                end
            end
            OP_UNREGISTER:
            begin
                if (s1_user_reg)
                begin
                    rsp_status_next = ST_UNAUTHORIZED;
                end
                else if (hits.owner_hit)
                begin
                    rsp_status_next = ST_OK;
                    cmd.clear       = 1'b1;
                    sel             = owner_sel;
                end
                else
                begin
                    rsp_status_next = ST_NOT_REG;
                end
            end
            default:
            begin
                rsp_status_next = ST_BAD_PARAM;
            end
        endcase
        wr_cmd = cmd;
        wr_sel = sel & {TABLE_ENTRIES{s1_fire}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            rsp_status_reg <= rsp_status_next;
            rsp_id_reg     <= rsp_id_next;
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.status   = rsp_status_reg;
    assign rsp.found_id = rsp_id_reg;

    `TNRT_ASSERT(a_wr_sel_onehot, $onehot0(wr_sel), "more than one table row written")
    `TNRT_ASSERT(a_fire_gives_result, s1_fire |=> rsp_valid_reg, "advancing item left no result")
    `TNRT_ASSERT(a_id_only_on_ok, rsp_valid_reg && (rsp_status_reg != ST_OK) |-> (rsp_id_reg == '0), "found_id set on failed request")
    `TNRT_ASSERT(a_write_only_ok, (|wr_sel) |-> (rsp_status_next == ST_OK), "table written on failed request")

endmodule
